### hw/rtl/i2cram_pkg.sv
// shared types and codes for the i2c register access master
// used by i2cram_core, i2cram_outq and i2c_register_access_master_unit
package i2cram_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_BEGIN_WR = 2'd1;
  localparam logic [1:0] OP_BEGIN_RD = 2'd2;
  localparam logic [1:0] OP_SUPPLY   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd1;

  // configuration reset values
  localparam logic [6:0] DEV_ADDR_RST = 7'd93;
  localparam logic [7:0] DELAY_RST    = 8'd1;

  // one result transaction
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       need_data;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last_byte;
    logic       done_res;
  } result_t;

endpackage

### hw/rtl/i2cram_core.sv
// bit-level i2c master state machine, one step per accepted transaction
// depends on i2cram_pkg (operation codes, result_t)
module i2cram_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          op,
  input  logic [15:0]         reg_address,
  input  logic [7:0]          byte_count,
  input  logic [7:0]          write_data,
  input  logic                sda_in,
  input  logic [6:0]          device_address,
  input  logic [7:0]          delay_ticks,
  output i2cram_pkg::result_t res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_TX0, PH_TX1, PH_TX2, PH_TX3,
    PH_AK0, PH_AK1, PH_AK2, PH_WAITD, PH_RX0, PH_RX1, PH_MK0, PH_MK1,
    PH_MK2, PH_SP0, PH_SP1, PH_SP2
  } phase_t;

  // which byte the next slave ack closes
  typedef enum logic [2:0] {
    STG_DEVW, STG_ADHI, STG_ADLO, STG_DATA, STG_DEVR
  } stage_t;

  phase_t      phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic [7:0]  delay_r, delay_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic        is_read_r, is_read_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;

  logic [7:0]  hold;
  logic [7:0]  rx_byte;
  logic        reload;
  logic [7:0]  rdata;
  logic        rvalid;
  logic        rlast;
  logic        done;

  // hold count per waveform step, zero treated as one tick
  assign hold    = (delay_ticks == 8'd0) ? 8'd0 : delay_ticks - 8'd1;
  assign rx_byte = {shift_r[6:0], sda_in};

  // next state for one transaction
  always_comb begin
    phase_nxt   = phase_r;
    stage_nxt   = stage_r;
    delay_nxt   = delay_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    addr_nxt    = addr_r;
    is_read_nxt = is_read_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    reload      = 1'b1;
    rdata       = 8'd0;
    rvalid      = 1'b0;
    rlast       = 1'b0;
    done        = 1'b0;

    case (op)
      i2cram_pkg::OP_BEGIN_WR, i2cram_pkg::OP_BEGIN_RD: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt    = reg_address;
          left_nxt    = byte_count;
          is_read_nxt = (op == i2cram_pkg::OP_BEGIN_RD);
          stage_nxt   = STG_DEVW;
          bit_nxt     = 3'd0;
          delay_nxt   = 8'd0;
          phase_nxt   = PH_ST0;
        end
      end
      i2cram_pkg::OP_SUPPLY: begin
        if (phase_r == PH_WAITD) begin
          stage_nxt = STG_DATA;
          left_nxt  = left_r - 8'd1;
          shift_nxt = write_data;
          bit_nxt   = 3'd0;
          phase_nxt = PH_TX0;
        end
      end
      default: begin
        if (phase_r != PH_IDLE) begin
          if (delay_r != 8'd0) begin
            delay_nxt = delay_r - 8'd1;
          end else begin
            case (phase_r)
              PH_ST0: begin
                sda_nxt   = 1'b1;
                scl_nxt   = 1'b1;
                phase_nxt = PH_ST1;
              end
              PH_ST1: begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_ST2;
              end
              PH_ST2: begin
                scl_nxt   = 1'b0;
                shift_nxt = {device_address, stage_r == STG_DEVR};
                bit_nxt   = 3'd0;
                phase_nxt = PH_TX0;
              end
              PH_TX0: begin
                sda_nxt   = shift_r[7];
                phase_nxt = PH_TX1;
              end
              PH_TX1: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_TX2;
              end
              PH_TX2: begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_TX3;
              end
              PH_TX3: begin
                if (bit_r == 3'd7) begin
                  sda_nxt   = 1'b1;
                  phase_nxt = PH_AK0;
                end else begin
                  bit_nxt   = bit_r + 3'd1;
                  shift_nxt = {shift_r[6:0], 1'b0};
                  phase_nxt = PH_TX0;
                end
              end
              PH_AK0: begin
                sda_nxt   = 1'b1;
                phase_nxt = PH_AK1;
              end
              PH_AK1: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_AK2;
              end
              PH_AK2: begin
                if (sda_in) begin
                  reload = 1'b0;
                end else begin
                  scl_nxt = 1'b0;
                  // route on to the next byte of the transaction
                  case (stage_r)
                    STG_DEVW: begin
                      stage_nxt = STG_ADHI;
                      shift_nxt = addr_r[15:8];
                      bit_nxt   = 3'd0;
                      phase_nxt = PH_TX0;
                    end
                    STG_ADHI: begin
                      stage_nxt = STG_ADLO;
                      shift_nxt = addr_r[7:0];
                      bit_nxt   = 3'd0;
                      phase_nxt = PH_TX0;
                    end
                    STG_ADLO: begin
                      if (is_read_r) begin
                        stage_nxt = STG_DEVR;
                        phase_nxt = PH_ST0;
                      end else begin
                        phase_nxt = (left_r != 8'd0) ? PH_WAITD : PH_SP0;
                      end
                    end
                    STG_DATA: begin
                      phase_nxt = (left_r != 8'd0) ? PH_WAITD : PH_SP0;
                    end
                    default: begin
                      if (left_r != 8'd0) begin
                        bit_nxt   = 3'd0;
                        phase_nxt = PH_RX0;
                      end else begin
                        phase_nxt = PH_SP0;
                      end
                    end
                  endcase
                end
              end
              PH_WAITD: begin
                reload = 1'b0;
              end
              PH_RX0: begin
                sda_nxt   = 1'b1;
                scl_nxt   = 1'b1;
                phase_nxt = PH_RX1;
              end
              PH_RX1: begin
                shift_nxt = rx_byte;
                scl_nxt   = 1'b0;
                if (bit_r == 3'd7) begin
                  rdata     = rx_byte;
                  rvalid    = 1'b1;
                  rlast     = (left_r == 8'd1);
                  left_nxt  = left_r - 8'd1;
                  phase_nxt = PH_MK0;
                end else begin
                  bit_nxt   = bit_r + 3'd1;
                  phase_nxt = PH_RX0;
                end
              end
              PH_MK0: begin
                // ack all but the final byte
                sda_nxt   = (left_r == 8'd0);
                phase_nxt = PH_MK1;
              end
              PH_MK1: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_MK2;
              end
              PH_MK2: begin
                scl_nxt = 1'b0;
                if (left_r != 8'd0) begin
                  bit_nxt   = 3'd0;
                  phase_nxt = PH_RX0;
                end else begin
                  phase_nxt = PH_SP0;
                end
              end
              PH_SP0: begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_SP1;
              end
              PH_SP1: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_SP2;
              end
              default: begin
                sda_nxt   = 1'b1;
                scl_nxt   = 1'b1;
                phase_nxt = PH_IDLE;
                done      = 1'b1;
                reload    = 1'b0;
              end
            endcase
            if (reload) begin
              delay_nxt = hold;
            end
          end
        end
      end
    endcase
  end

  // result of this transaction
  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.need_data  = (phase_nxt == PH_WAITD);
    res.read_data  = rdata;
    res.read_valid = rvalid;
    res.last_byte  = rlast;
    res.done_res   = done;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      stage_r   <= STG_DEVW;
      delay_r   <= 8'd0;
      bit_r     <= 3'd0;
      shift_r   <= 8'd0;
      left_r    <= 8'd0;
      addr_r    <= 16'd0;
      is_read_r <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      stage_r   <= stage_nxt;
      delay_r   <= delay_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      left_r    <= left_nxt;
      addr_r    <= addr_nxt;
      is_read_r <= is_read_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

  // bus released whenever no transaction runs
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> scl_r && sda_r)
    else $error("bus not released while idle");

  // clock held low while waiting for a write byte
  a_waitd_scl_low: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAITD |-> !scl_r)
    else $error("scl high while waiting for data");

  // received bytes only occur in read transactions
  a_rx_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.read_valid |-> is_read_r)
    else $error("read byte in a write transaction");

endmodule

### hw/rtl/i2cram_outq.sv
// two-entry result queue between the state machine and the result channel
// depends on i2cram_pkg (result_t)
module i2cram_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cram_pkg::result_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cram_pkg::result_t out_data
);

  i2cram_pkg::result_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && count_r == 2'd2))
    else $error("push into full result queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r ^ rd_ptr_r) == (count_r == 2'd1))
    else $error("queue pointers disagree with count");

endmodule

### hw/rtl/i2c_register_access_master_unit.sv
// i2c register access master, top level
// depends on i2cram_pkg, i2cram_core and i2cram_outq
//
// usage
//   input channel (in_valid/in_ready): one transaction per operation: tick,
//   begin write, begin read or supply write byte. ticks carry sampled sda
//   and advance the bus waveform; delay_ticks ticks form one waveform step.
//   result channel (out_valid/out_ready): exactly one result per input
//   transaction, in order, giving scl/sda levels, busy, need_data, the
//   received byte with its valid and last flags, and done on stop.
//   configuration channel (cfg_valid/cfg_ready): index 0 device address,
//   index 1 delay_ticks; cfg_ready is always high, write only when idle.
// stepping and throughput
//   the state machine steps on the accepting edge, and the result is written
//   into the result queue at that edge, behind any results not yet taken.
//   one transaction per cycle is accepted while the result queue is not full.
// reset and stall
//   reset returns to idle with both lines released, address 93, delay 1.
//   a two-entry result queue absorbs receiver stalls; in_ready drops only
//   when both entries hold results not yet taken.
module i2c_register_access_master_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_operation,
  input  logic [15:0]                       in_reg_address,
  input  logic [7:0]                        in_byte_count,
  input  logic [7:0]                        in_write_data,
  input  logic                              in_sda_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_scl_level,
  output logic                              out_sda_level,
  output logic                              out_busy_res,
  output logic                              out_need_data,
  output logic [7:0]                        out_read_data,
  output logic                              out_read_valid,
  output logic                              out_last_byte,
  output logic                              out_done_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2cram_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                        cfg_data
);

  logic [6:0]          dev_addr_r;
  logic [7:0]          delay_r;
  logic                accept;
  logic                full;
  i2cram_pkg::result_t core_res;
  i2cram_pkg::result_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cram_pkg::DEV_ADDR_RST;
      delay_r    <= i2cram_pkg::DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cram_pkg::CFG_DEV_ADDR: dev_addr_r <= cfg_data[6:0];
        i2cram_pkg::CFG_DELAY:    delay_r    <= cfg_data;
        default:                  dev_addr_r <= dev_addr_r;
      endcase
    end
  end

  i2cram_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .op             (in_operation),
    .reg_address    (in_reg_address),
    .byte_count     (in_byte_count),
    .write_data     (in_write_data),
    .sda_in         (in_sda_in),
    .device_address (dev_addr_r),
    .delay_ticks    (delay_r),
    .res            (core_res)
  );

  i2cram_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_res),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  // result fields
  assign out_scl_level  = head.scl_level;
  assign out_sda_level  = head.sda_level;
  assign out_busy_res   = head.busy_res;
  assign out_need_data  = head.need_data;
  assign out_read_data  = head.read_data;
  assign out_read_valid = head.read_valid;
  assign out_last_byte  = head.last_byte;
  assign out_done_res   = head.done_res;

endmodule

### tb/tb_i2c_register_access_master_unit.sv
// self-checking testbench for the i2c register access master unit
// drives tick, begin and supply transactions and predicts every result
// depends on i2cram_pkg and the i2c_register_access_master_unit rtl
module tb_i2c_register_access_master_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [i2cram_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  // waveform steps of the bus engine
  typedef enum logic [4:0] {
    BUS_IDLE, START_REL, START_SDA, START_SCL,
    TX_SDA, TX_SCL_HI, TX_SCL_LO, TX_NEXT,
    ACK_REL, ACK_SCL_HI, ACK_WAIT, DATA_WAIT,
    RX_SCL_HI, RX_SAMPLE, MACK_SDA, MACK_SCL_HI, MACK_SCL_LO,
    STOP_SDA, STOP_SCL, STOP_REL
  } bus_phase_t;

  // which byte the next slave ack closes
  typedef enum logic [2:0] {
    BYTE_DEV_WR, BYTE_ADDR_HI, BYTE_ADDR_LO, BYTE_DATA, BYTE_DEV_RD
  } ack_stage_t;

  typedef enum {DRV_FREE, DRV_FINISH, DRV_ONES, DRV_ZEROS} drive_mode_t;
  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} sink_mode_t;

  // bus master predictor plus the store of expected results
  class master_scoreboard;
    logic [6:0]  dev_addr;
    logic [7:0]  step_ticks;
    bus_phase_t  phase;
    ack_stage_t  ack_for;
    logic [7:0]  hold_left;
    logic [2:0]  bit_pos;
    logic [7:0]  shift_reg;
    logic [7:0]  bytes_to_go;
    logic [15:0] target_reg;
    logic        reading;
    logic        scl;
    logic        sda;
    i2cram_pkg::result_t pending_results[$];
    int          errors;

    function new();
      dev_addr    = i2cram_pkg::DEV_ADDR_RST;
      step_ticks  = i2cram_pkg::DELAY_RST;
      phase       = BUS_IDLE;
      ack_for     = BYTE_DEV_WR;
      hold_left   = '0;
      bit_pos     = '0;
      shift_reg   = '0;
      bytes_to_go = '0;
      target_reg  = '0;
      reading     = 1'b0;
      scl         = 1'b1;
      sda         = 1'b1;
      errors      = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function void write_reg(logic [i2cram_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        i2cram_pkg::CFG_DEV_ADDR: dev_addr = data[6:0];
        i2cram_pkg::CFG_DELAY:    step_ticks = data;
        default: ;
      endcase
    endfunction

    function void load_byte(logic [7:0] b);
      shift_reg = b;
      bit_pos   = '0;
      phase     = TX_SDA;
    endfunction

    // next step once the slave has acked
    function void after_ack();
      case (ack_for)
        BYTE_DEV_WR: begin
          ack_for = BYTE_ADDR_HI;
          load_byte(target_reg[15:8]);
        end
        BYTE_ADDR_HI: begin
          ack_for = BYTE_ADDR_LO;
          load_byte(target_reg[7:0]);
        end
        BYTE_ADDR_LO: begin
          if (reading) begin
            ack_for = BYTE_DEV_RD;
            phase   = START_REL;
          end else if (bytes_to_go != 8'd0) phase = DATA_WAIT;
          else phase = STOP_SDA;
        end
        BYTE_DATA: begin
          if (bytes_to_go != 8'd0) phase = DATA_WAIT;
          else phase = STOP_SDA;
        end
        default: begin
          if (bytes_to_go != 8'd0) begin
            bit_pos = '0;
            phase   = RX_SCL_HI;
          end else phase = STOP_SDA;
        end
      endcase
    endfunction

    // advance the bus engine by one input transaction and queue its result
    function void predict_step(logic [1:0] op, logic [15:0] reg_a, logic [7:0] count,
                               logic [7:0] wdata, logic sda_smp);
      i2cram_pkg::result_t r;
      logic [7:0] hold;
      bit         reload;
      r      = '0;
      hold   = (step_ticks != 8'd0) ? step_ticks - 8'd1 : 8'd0;
      reload = 1'b1;
      if (op == i2cram_pkg::OP_BEGIN_WR || op == i2cram_pkg::OP_BEGIN_RD) begin
        if (phase == BUS_IDLE) begin
          target_reg  = reg_a;
          bytes_to_go = count;
          reading     = (op == i2cram_pkg::OP_BEGIN_RD);
          ack_for     = BYTE_DEV_WR;
          bit_pos     = '0;
          hold_left   = '0;
          phase       = START_REL;
        end
      end else if (op == i2cram_pkg::OP_SUPPLY) begin
        if (phase == DATA_WAIT) begin
          ack_for     = BYTE_DATA;
          bytes_to_go = bytes_to_go - 8'd1;
          load_byte(wdata);
        end
      end else if (phase != BUS_IDLE) begin
        if (hold_left != 8'd0) hold_left = hold_left - 8'd1;
        else begin
          case (phase)
            START_REL: begin
              sda   = 1'b1;
              scl   = 1'b1;
              phase = START_SDA;
            end
            START_SDA: begin
              sda   = 1'b0;
              phase = START_SCL;
            end
            START_SCL: begin
              scl = 1'b0;
              load_byte({dev_addr, ack_for == BYTE_DEV_RD});
            end
            TX_SDA: begin
              sda   = shift_reg[7];
              phase = TX_SCL_HI;
            end
            TX_SCL_HI: begin
              scl   = 1'b1;
              phase = TX_SCL_LO;
            end
            TX_SCL_LO: begin
              scl   = 1'b0;
              phase = TX_NEXT;
            end
            TX_NEXT: begin
              if (bit_pos == 3'd7) begin
                sda   = 1'b1;
                phase = ACK_REL;
              end else begin
                bit_pos++;
                shift_reg = shift_reg << 1;
                phase     = TX_SDA;
              end
            end
            ACK_REL: begin
              sda   = 1'b1;
              phase = ACK_SCL_HI;
            end
            ACK_SCL_HI: begin
              scl   = 1'b1;
              phase = ACK_WAIT;
            end
            // scl held high until the slave pulls sda low
            ACK_WAIT: begin
              if (sda_smp) reload = 1'b0;
              else begin
                scl = 1'b0;
                after_ack();
              end
            end
            DATA_WAIT: reload = 1'b0;
            RX_SCL_HI: begin
              sda   = 1'b1;
              scl   = 1'b1;
              phase = RX_SAMPLE;
            end
            RX_SAMPLE: begin
              shift_reg = {shift_reg[6:0], sda_smp};
              scl       = 1'b0;
              if (bit_pos == 3'd7) begin
                r.read_data  = shift_reg;
                r.read_valid = 1'b1;
                r.last_byte  = (bytes_to_go == 8'd1);
                bytes_to_go  = bytes_to_go - 8'd1;
                phase        = MACK_SDA;
              end else begin
                bit_pos++;
                phase = RX_SCL_HI;
              end
            end
            // ack every byte but the last, which gets a nack
            MACK_SDA: begin
              sda   = (bytes_to_go == 8'd0);
              phase = MACK_SCL_HI;
            end
            MACK_SCL_HI: begin
              scl   = 1'b1;
              phase = MACK_SCL_LO;
            end
            MACK_SCL_LO: begin
              scl = 1'b0;
              if (bytes_to_go != 8'd0) begin
                bit_pos = '0;
                phase   = RX_SCL_HI;
              end else phase = STOP_SDA;
            end
            STOP_SDA: begin
              sda   = 1'b0;
              phase = STOP_SCL;
            end
            STOP_SCL: begin
              scl   = 1'b1;
              phase = STOP_REL;
            end
            default: begin
              sda       = 1'b1;
              scl       = 1'b1;
              phase     = BUS_IDLE;
              r.done_res = 1'b1;
              reload    = 1'b0;
            end
          endcase
          if (reload) hold_left = hold;
        end
      end
      r.scl_level = scl;
      r.sda_level = sda;
      r.busy_res  = (phase != BUS_IDLE);
      r.need_data = (phase == DATA_WAIT);
      pending_results.push_back(r);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task compare_result(i2cram_pkg::result_t got);
      i2cram_pkg::result_t want;
      if (pending_results.size() == 0) report("result with no transaction outstanding");
      else begin
        want = pending_results.pop_front();
        check_field("scl_level", got.scl_level, want.scl_level);
        check_field("sda_level", got.sda_level, want.sda_level);
        check_field("busy_res", got.busy_res, want.busy_res);
        check_field("need_data", got.need_data, want.need_data);
        check_field("read_data", got.read_data, want.read_data);
        check_field("read_valid", got.read_valid, want.read_valid);
        check_field("last_byte", got.last_byte, want.last_byte);
        check_field("done_res", got.done_res, want.done_res);
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_operation = i2cram_pkg::OP_TICK;
  logic [15:0]          in_reg_address = '0;
  logic [7:0]           in_byte_count = '0;
  logic [7:0]           in_write_data = '0;
  logic                 in_sda_in = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_scl_level;
  logic                 out_sda_level;
  logic                 out_busy_res;
  logic                 out_need_data;
  logic [7:0]           out_read_data;
  logic                 out_read_valid;
  logic                 out_last_byte;
  logic                 out_done_res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [i2cram_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  master_scoreboard    sb = new();
  i2cram_pkg::result_t seen;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  sink_mode_t          sink_mode = RX_OPEN;
  int                  sink_left = 0;
  logic [7:0]          sink_phase = '0;

  i2c_register_access_master_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_reg_address (in_reg_address),
    .in_byte_count  (in_byte_count),
    .in_write_data  (in_write_data),
    .in_sda_in      (in_sda_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_busy_res   (out_busy_res),
    .out_need_data  (out_need_data),
    .out_read_data  (out_read_data),
    .out_read_valid (out_read_valid),
    .out_last_byte  (out_last_byte),
    .out_done_res   (out_done_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure in one of four randomly chosen patterns
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(3));
      sink_left = $urandom_range(16, 96);
    end
    sink_left--;
    sink_phase++;
    case (sink_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(1));
      RX_PERIODIC: out_ready <= (sink_phase[1:0] == 2'b00);
      default:     out_ready <= ($urandom_range(9) == 0);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.scl_level  = out_scl_level;
      seen.sda_level  = out_sda_level;
      seen.busy_res   = out_busy_res;
      seen.need_data  = out_need_data;
      seen.read_data  = out_read_data;
      seen.read_valid = out_read_valid;
      seen.last_byte  = out_last_byte;
      seen.done_res   = out_done_res;
      sb.compare_result(seen);
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transaction, sent in bursts with random gaps
  task automatic send_item(logic [1:0] op, logic [15:0] reg_a, logic [7:0] count,
                           logic [7:0] wdata, logic sda_smp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? 150 : $urandom_range(1, 20);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_reg_address <= reg_a;
    in_byte_count  <= count;
    in_write_data  <= wdata;
    in_sda_in      <= sda_smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_step(op, reg_a, count, wdata, sda_smp);
    burst_left--;
    @(negedge clk);
  endtask

  // hold the sender until every expected result has arrived
  task automatic drain_results(int settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_cfg(logic [i2cram_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data,
                           bit is_last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    if (is_last) cfg_valid <= 1'b0;
  endtask

  // choose the next transaction from the predicted bus state
  task automatic pick_item(drive_mode_t mode, output logic [1:0] op,
                           output logic [15:0] reg_a, output logic [7:0] count,
                           output logic [7:0] wdata, output logic sda_smp);
    op      = i2cram_pkg::OP_TICK;
    reg_a   = 16'($urandom);
    count   = 8'($urandom);
    wdata   = 8'($urandom);
    sda_smp = 1'($urandom);
    if (mode == DRV_ONES || mode == DRV_ZEROS) begin
      wdata   = {8{mode == DRV_ONES}};
      sda_smp = (mode == DRV_ONES);
    end
    if (mode == DRV_FREE && $urandom_range(99) < 8) begin
      // noise: any operation, a stray begin on an idle bus stays short
      op = 2'($urandom_range(3));
      if (sb.phase == BUS_IDLE) count = count % 4;
    end else if (sb.phase == BUS_IDLE) begin
      case ($urandom_range(9))
        0:          op = i2cram_pkg::OP_TICK;
        1, 2, 3, 4: op = i2cram_pkg::OP_BEGIN_WR;
        default:    op = i2cram_pkg::OP_BEGIN_RD;
      endcase
      count = ($urandom_range(9) == 0) ? 8'($urandom_range(4, 8)) : 8'($urandom_range(3));
    end else if (sb.phase == DATA_WAIT) begin
      if (mode != DRV_FREE || $urandom_range(9) < 8) op = i2cram_pkg::OP_SUPPLY;
    end else if (sb.phase == ACK_WAIT && sb.hold_left == 8'd0) begin
      // slave sometimes stretches the ack
      sda_smp = (mode == DRV_FREE) && ($urandom_range(3) == 0);
    end
  endtask

  task automatic finish_txn(drive_mode_t mode);
    logic [1:0]  op;
    logic [15:0] reg_a;
    logic [7:0]  count;
    logic [7:0]  wdata;
    logic        sda_smp;
    while (sb.phase != BUS_IDLE) begin
      pick_item(mode, op, reg_a, count, wdata, sda_smp);
      send_item(op, reg_a, count, wdata, sda_smp);
    end
  endtask

  task automatic run_txn(logic [1:0] op, logic [15:0] reg_a, logic [7:0] count,
                         drive_mode_t mode);
    send_item(op, reg_a, count, 8'h00, 1'b0);
    finish_txn(mode);
  endtask

  // random traffic, counting only transactions that change the block
  task automatic run_random(int effective, bit pause_mid);
    logic [1:0]  op;
    logic [15:0] reg_a;
    logic [7:0]  count;
    logic [7:0]  wdata;
    logic        sda_smp;
    int          sent;
    bit          useful;
    sent = 0;
    while (sent < effective) begin
      pick_item(DRV_FREE, op, reg_a, count, wdata, sda_smp);
      if (op == i2cram_pkg::OP_TICK) useful = (sb.phase != BUS_IDLE);
      else if (op == i2cram_pkg::OP_SUPPLY) useful = (sb.phase == DATA_WAIT);
      else useful = (sb.phase == BUS_IDLE);
      send_item(op, reg_a, count, wdata, sda_smp);
      if (useful) begin
        sent++;
        if (pause_mid && sent == effective / 2) drain_results(1);
      end
    end
    finish_txn(DRV_FINISH);
    drain_results(4);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle ticks and a supply with nothing awaited
    send_item(i2cram_pkg::OP_TICK, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send_item(i2cram_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 1'b0);
    send_item(i2cram_pkg::OP_SUPPLY, 16'h0000, 8'h00, 8'hFF, 1'b0);
    // two-byte write to the top register; begin while busy and early supply ignored
    send_item(i2cram_pkg::OP_BEGIN_WR, 16'hFFFF, 8'd2, 8'h00, 1'b0);
    send_item(i2cram_pkg::OP_BEGIN_RD, 16'h0000, 8'hFF, 8'h00, 1'b1);
    send_item(i2cram_pkg::OP_SUPPLY, 16'h0000, 8'h00, 8'h5A, 1'b0);
    finish_txn(DRV_ONES);
    // zero-length write and read, then short reads and a write of zeros
    run_txn(i2cram_pkg::OP_BEGIN_WR, 16'h0000, 8'd0, DRV_ZEROS);
    run_txn(i2cram_pkg::OP_BEGIN_RD, 16'hA5C3, 8'd0, DRV_ONES);
    run_txn(i2cram_pkg::OP_BEGIN_RD, 16'h0000, 8'd1, DRV_ZEROS);
    run_txn(i2cram_pkg::OP_BEGIN_RD, 16'hFFFF, 8'd3, DRV_ONES);
    run_txn(i2cram_pkg::OP_BEGIN_WR, 16'h8001, 8'd1, DRV_ZEROS);

    // reset settings, with one pause for the result queue to empty
    run_random(80, 1'b1);

    // top address, zero delay treated as one tick
    write_cfg(i2cram_pkg::CFG_DEV_ADDR, 8'hFF, 1'b0);
    write_cfg(i2cram_pkg::CFG_DELAY, 8'h00, 1'b1);
    run_random(30, 1'b0);

    // unused index, then random address at a few ticks per step, one short write
    write_cfg(CFG_SPARE, 8'hFF, 1'b0);
    write_cfg(i2cram_pkg::CFG_DEV_ADDR, 8'($urandom), 1'b0);
    write_cfg(i2cram_pkg::CFG_DELAY, 8'($urandom_range(2, 3)), 1'b1);
    run_txn(i2cram_pkg::OP_BEGIN_WR, 16'h3CC3, 8'd0, DRV_FREE);

    drain_results(8);
    if (sb.pending_results.size() != 0) sb.report("results still expected at end of run");
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
